FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL modules.
// ----------------------------------------------------------------------------
// Each expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/htprb_pkg.sv
// ----------------------------------------------------------------------------
// htprb_pkg
// Shared types and constants of the header-triggered packet ring buffer.
// ----------------------------------------------------------------------------
package htprb_pkg;

  localparam int OCC_W = 5;

  typedef enum logic [2:0] {
    ST_STORED = 3'd0,
    ST_NEWMSG = 3'd1,
    ST_FULL   = 3'd2,
    ST_NOROOM = 3'd3,
    ST_BYTE   = 3'd4,
    ST_EMPTY  = 3'd5
  } status_t;

  localparam logic OP_RX  = 1'b0;
  localparam logic OP_POP = 1'b1;

  // Marker match progress
  localparam logic [2:0] MS_PLUS = 3'd1;
  localparam logic [2:0] MS_M    = 3'd2;
  localparam logic [2:0] MS_I    = 3'd3;
  localparam logic [2:0] MS_P    = 3'd4;
  localparam logic [2:0] MS_R    = 3'd5;

  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_M    = 8'h4D;
  localparam logic [7:0] CH_I    = 8'h49;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_R    = 8'h52;

  typedef struct packed {
    logic rx;        // accept a receive beat
    logic pop;       // accept a pop
    logic len_eval;  // evaluate the popped slot length
    logic rd;        // issue one byte read of the popped slot
  } dp_cmd_t;

  typedef struct packed {
    logic q_empty;   // no claimed slots
    logic n_zero;    // popped slot holds no bytes
    logic rd_last;   // current read is the final byte
  } dp_sts_t;

endpackage

FILE: hw/rtl/htprb_ram.sv
// ----------------------------------------------------------------------------
// htprb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module htprb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/htprb_ctrl.sv
// ----------------------------------------------------------------------------
// htprb_ctrl
// Sequencer: accepts commands and walks a pop through length fetch and
// byte streaming.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module htprb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_opcode,
  input  htprb_pkg::dp_sts_t sts,
  output htprb_pkg::dp_cmd_t cmd,
  output logic              busy
);

  import htprb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LEN    = 4'b0010,
    S_STREAM = 4'b0100,
    S_FLUSH  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_opcode == OP_POP) begin
            cmd.pop = 1'b1;
            if (!sts.q_empty) begin
              state_nxt = S_LEN;
            end
          end else begin
            cmd.rx = 1'b1;
          end
        end
      end
      S_LEN: begin
        cmd.len_eval = 1'b1;
        state_nxt    = sts.n_zero ? S_IDLE : S_STREAM;
      end
      S_STREAM: begin
        cmd.rd = 1'b1;
        if (sts.rd_last) begin
          state_nxt = S_FLUSH;
        end
      end
      // wait for the last byte to leave the read register
      S_FLUSH: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_NEXT(a_pop_to_len, cmd.pop && !sts.q_empty, state_r == S_LEN)
  `ASSERT_IMPL(a_cmd_excl, 1'b1, $onehot0(cmd))
  `ASSERT_IMPL(a_busy_no_accept, busy, !cmd.rx && !cmd.pop)

endmodule

FILE: hw/rtl/htprb_dp.sv
// ----------------------------------------------------------------------------
// htprb_dp
// Datapath: marker matcher, ring pointers, slot length and byte memories,
// result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module htprb_dp #(
  parameter int SLOTS        = 16,
  parameter int BUFFER_BYTES = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            in_rx_byte,
  input  htprb_pkg::dp_cmd_t    cmd,
  output htprb_pkg::dp_sts_t    sts,
  output logic                  out_valid,
  output htprb_pkg::status_t    out_status,
  output logic [7:0]            out_data_byte,
  output logic                  out_last,
  output logic [htprb_pkg::OCC_W-1:0] out_occupancy
);

  import htprb_pkg::*;

  localparam int SW  = $clog2(SLOTS);
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int LW  = $clog2(BUFFER_BYTES);
  localparam int BAW = SW + LW;

  // control state
  logic [2:0]    match_r, match_nxt;
  logic [SW-1:0] wr_idx_r, wr_idx_nxt;
  logic [SW-1:0] rd_idx_r, rd_idx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] wslot_r, wslot_nxt;
  logic          wvalid_r, wvalid_nxt;
  logic [LW-1:0] wlen_r, wlen_nxt;
  logic          byte_vld_r, byte_vld_nxt;
  logic          out_valid_r, out_valid_nxt;

  // pop payload
  logic [SW-1:0] pop_slot_r, pop_slot_nxt;
  logic          pop_use_wr_r, pop_use_wr_nxt;
  logic [LW-1:0] pop_wlen_r, pop_wlen_nxt;
  logic [LW-1:0] n_r, n_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic          byte_last_r, byte_last_nxt;

  // result payload
  status_t          status_r, status_nxt;
  logic [7:0]       data_r, data_nxt;
  logic             last_r, last_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;

  // matcher and store decode
  logic [2:0]    stage;
  logic [2:0]    rx_match;
  logic          claim;
  logic          rx_drop;
  logic [SW-1:0] tgt_slot;
  logic [LW-1:0] tgt_len;
  logic          can_store;
  logic [LW-1:0] pop_n;

  // memories
  logic           bm_we;
  logic [BAW-1:0] bm_waddr;
  logic [BAW-1:0] bm_raddr;
  logic [7:0]     bm_rdata;
  logic           lm_we;
  logic [LW-1:0]  lm_wdata;
  logic [LW-1:0]  lm_rdata;

  htprb_ram #(.WIDTH(8), .DEPTH(SLOTS * (2 ** LW))) u_bytes (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (in_rx_byte),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  htprb_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_len (
    .clk   (clk),
    .we    (lm_we),
    .waddr (tgt_slot),
    .wdata (lm_wdata),
    .raddr (rd_idx_r),
    .rdata (lm_rdata)
  );

  assign bm_raddr = {pop_slot_r, idx_r};

  // marker match; a plus always restarts
  always_comb begin
    stage    = (in_rx_byte == CH_PLUS) ? MS_PLUS : match_r;
    rx_match = MS_PLUS;
    claim    = 1'b0;
    rx_drop  = 1'b0;
    case (stage)
      MS_PLUS: rx_match = (in_rx_byte == CH_PLUS) ? MS_M : MS_PLUS;
      MS_M:    rx_match = (in_rx_byte == CH_M) ? MS_I : MS_PLUS;
      MS_I:    rx_match = (in_rx_byte == CH_I) ? MS_P : MS_PLUS;
      MS_P:    rx_match = (in_rx_byte == CH_P) ? MS_R : MS_PLUS;
      MS_R: begin
        rx_match = MS_PLUS;
        if (in_rx_byte == CH_R) begin
          if (cnt_r == CW'(SLOTS)) begin
            rx_drop = 1'b1;
          end else begin
            claim = 1'b1;
          end
        end
      end
      default: rx_match = MS_PLUS;
    endcase
  end

  assign tgt_slot  = claim ? wr_idx_r : wslot_r;
  assign tgt_len   = claim ? '0 : wlen_r;
  assign can_store = claim || (wvalid_r && (wlen_r < LW'(BUFFER_BYTES - 1)));
  assign bm_waddr  = {tgt_slot, tgt_len};
  assign lm_wdata  = tgt_len + 1'b1;
  assign pop_n     = pop_use_wr_r ? pop_wlen_r : lm_rdata;

  assign sts.q_empty = (cnt_r == '0);
  assign sts.n_zero  = (pop_n == '0);
  assign sts.rd_last = (idx_r == n_r - 1'b1);

  always_comb begin
    match_nxt      = match_r;
    wr_idx_nxt     = wr_idx_r;
    rd_idx_nxt     = rd_idx_r;
    cnt_nxt        = cnt_r;
    wslot_nxt      = wslot_r;
    wvalid_nxt     = wvalid_r;
    wlen_nxt       = wlen_r;
    byte_vld_nxt   = 1'b0;
    out_valid_nxt  = 1'b0;
    pop_slot_nxt   = pop_slot_r;
    pop_use_wr_nxt = pop_use_wr_r;
    pop_wlen_nxt   = pop_wlen_r;
    n_nxt          = n_r;
    idx_nxt        = idx_r;
    byte_last_nxt  = byte_last_r;
    status_nxt     = status_r;
    data_nxt       = data_r;
    last_nxt       = last_r;
    occ_nxt        = occ_r;
    bm_we          = 1'b0;
    lm_we          = 1'b0;

    if (cmd.rx) begin
      match_nxt  = rx_match;
      status_nxt = ST_STORED;
      if (claim) begin
        wslot_nxt  = wr_idx_r;
        wr_idx_nxt = (wr_idx_r == SW'(SLOTS - 1)) ? '0 : wr_idx_r + 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        wvalid_nxt = 1'b1;
        status_nxt = ST_NEWMSG;
      end
      if (rx_drop) begin
        status_nxt = ST_FULL;
      end else if (can_store) begin
        bm_we    = 1'b1;
        lm_we    = 1'b1;
        wlen_nxt = tgt_len + 1'b1;
      end else begin
        status_nxt = ST_NOROOM;
      end
      out_valid_nxt = 1'b1;
      data_nxt      = '0;
      last_nxt      = 1'b1;
      occ_nxt       = OCC_W'(cnt_nxt);
    end

    if (cmd.pop) begin
      if (cnt_r == '0) begin
        out_valid_nxt = 1'b1;
        status_nxt    = ST_EMPTY;
        data_nxt      = '0;
        last_nxt      = 1'b1;
        occ_nxt       = OCC_W'(cnt_r);
      end else begin
        pop_slot_nxt   = rd_idx_r;
        rd_idx_nxt     = (rd_idx_r == SW'(SLOTS - 1)) ? '0 : rd_idx_r + 1'b1;
        cnt_nxt        = cnt_r - 1'b1;
        // the live write slot's length sits in wlen_r, not yet trusted in memory
        pop_use_wr_nxt = wvalid_r && (wslot_r == rd_idx_r);
        pop_wlen_nxt   = wlen_r;
        if (wvalid_r && (wslot_r == rd_idx_r)) begin
          wlen_nxt = '0;
        end
      end
    end

    if (cmd.len_eval) begin
      n_nxt   = pop_n;
      idx_nxt = '0;
      if (pop_n == '0) begin
        out_valid_nxt = 1'b1;
        status_nxt    = ST_EMPTY;
        data_nxt      = '0;
        last_nxt      = 1'b1;
        occ_nxt       = OCC_W'(cnt_r);
      end
    end

    if (cmd.rd) begin
      idx_nxt       = idx_r + 1'b1;
      byte_vld_nxt  = 1'b1;
      byte_last_nxt = sts.rd_last;
    end

    if (byte_vld_r) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ST_BYTE;
      data_nxt      = bm_rdata;
      last_nxt      = byte_last_r;
      occ_nxt       = OCC_W'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r     <= MS_PLUS;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      cnt_r       <= '0;
      wslot_r     <= '0;
      wvalid_r    <= 1'b0;
      wlen_r      <= '0;
      byte_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      match_r     <= match_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      cnt_r       <= cnt_nxt;
      wslot_r     <= wslot_nxt;
      wvalid_r    <= wvalid_nxt;
      wlen_r      <= wlen_nxt;
      byte_vld_r  <= byte_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pop_slot_r   <= pop_slot_nxt;
    pop_use_wr_r <= pop_use_wr_nxt;
    pop_wlen_r   <= pop_wlen_nxt;
    n_r          <= n_nxt;
    idx_r        <= idx_nxt;
    byte_last_r  <= byte_last_nxt;
    status_r     <= status_nxt;
    data_r       <= data_nxt;
    last_r       <= last_nxt;
    occ_r        <= occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_data_byte = data_r;
  assign out_last      = last_r;
  assign out_occupancy = occ_r;

  `ASSERT_IMPL(a_cnt_range, 1'b1, cnt_r <= CW'(SLOTS))
  `ASSERT_IMPL(a_wlen_range, 1'b1, wlen_r <= LW'(BUFFER_BYTES - 1))
  `ASSERT_NEXT(a_last_byte_ends, byte_vld_r && byte_last_r, !byte_vld_r)

endmodule

FILE: hw/rtl/header_triggered_packet_ring_buffer_top.sv
// ----------------------------------------------------------------------------
// header_triggered_packet_ring_buffer_top
// Marker-triggered message capture into a ring of slot buffers.
// ----------------------------------------------------------------------------
// A receive beat leaves busy low, so bytes may be issued every cycle; its
// single result shows out_valid in the next cycle. A pop of a slot holding n
// bytes keeps busy high through the slot length read, one byte read per byte
// from the byte memory's single read port and a drain of the read register,
// so the next item waits until busy falls; the bytes come out on consecutive
// cycles with out_last on the final one. A pop that finds the queue empty
// leaves busy low.
// The receiver cannot stall: every out_valid cycle must be consumed.
module header_triggered_packet_ring_buffer_top #(
  parameter int SLOTS        = 16,
  parameter int BUFFER_BYTES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_opcode,
  input  logic [7:0]                  in_rx_byte,
  output logic                        out_valid,
  output logic [2:0]                  out_status,
  output logic [7:0]                  out_data_byte,
  output logic                        out_last,
  output logic [htprb_pkg::OCC_W-1:0] out_occupancy
);

  import htprb_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  status_t status;

  htprb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  htprb_dp #(
    .SLOTS        (SLOTS),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_rx_byte    (in_rx_byte),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_status    (status),
    .out_data_byte (out_data_byte),
    .out_last      (out_last),
    .out_occupancy (out_occupancy)
  );

  assign out_status = status;

endmodule
